FILE: design/mcfb_pkg.sv
// Shared types and constants of the Modbus command frame builder.
package mcfb_pkg;

    localparam int REQ_TYPE_W  = 5;
    localparam int VALUE_W     = 23;
    localparam int BYTE_W      = 8;

    // Command codes.
    localparam logic [4:0] REQ_PUMP_READ      = 5'd0;
    localparam logic [4:0] REQ_INV_BLOCK1     = 5'd1;
    localparam logic [4:0] REQ_INV_BLOCK2     = 5'd2;
    localparam logic [4:0] REQ_ONOFF_FIRST    = 5'd3;
    localparam logic [4:0] REQ_ONOFF_LAST     = 5'd12;
    localparam logic [4:0] REQ_CO_SETPOINT    = 5'd13;
    localparam logic [4:0] REQ_CO_DELTA       = 5'd14;
    localparam logic [4:0] REQ_EEV_SETPOINT   = 5'd15;
    localparam logic [4:0] REQ_EEV_MAX_PULSES = 5'd16;
    localparam logic [4:0] REQ_EEV_MIN_POS    = 5'd17;
    localparam logic [4:0] REQ_WORK_POWER     = 5'd18;

    // Frame constants and function codes.
    localparam logic [7:0] PUMP_ADDR     = 8'h41;
    localparam logic [7:0] PUMP_END      = 8'hFF;
    localparam logic [7:0] FN_PUMP_READ  = 8'h01;
    localparam logic [7:0] FN_FORCE      = 8'h03;
    localparam logic [7:0] FN_CO         = 8'h0C;
    localparam logic [7:0] FN_SUMP       = 8'h0B;
    localparam logic [7:0] FN_COLD_PUMP  = 8'h0A;
    localparam logic [7:0] FN_HOT_PUMP   = 8'h09;
    localparam logic [7:0] FN_CO_SET     = 8'h04;
    localparam logic [7:0] FN_CO_DELTA   = 8'h05;
    localparam logic [7:0] FN_EEV_SET    = 8'h08;
    localparam logic [7:0] FN_EEV_MAX    = 8'h0D;
    localparam logic [7:0] FN_EEV_MIN    = 8'h0F;
    localparam logic [7:0] FN_POWER      = 8'h0E;
    localparam logic [7:0] FN_INV_READ   = 8'h03;

    // Configuration register indexes.
    localparam logic [1:0] REG_INV_ADDR   = 2'd0;
    localparam logic [1:0] REG_INV_FIRST  = 2'd1;
    localparam logic [1:0] REG_BLOCK_CNT  = 2'd2;

    typedef enum logic [1:0] {
        KIND_PUMP,
        KIND_INV,
        KIND_BAD
    } kind_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SPLIT,
        MODE_ROUND,
        MODE_POWER
    } mode_t;

    typedef struct packed {
        logic [7:0]  inv_addr;
        logic [15:0] inv_first;
        logic [6:0]  block_cnt;
    } cfg_t;

    // One classified frame waiting for the back end. Byte i of the frame is fbytes[i];
    // when split is set, bytes 2 and 3 become split_val / 100 and split_val % 100.
    typedef struct packed {
        kind_t           kind;
        logic [5:0][7:0] fbytes;
        logic            split;
        logic [14:0]     split_val;
    } desc_t;

endpackage

FILE: design/mcfb_req_if.sv
// Command channel interface: command code and value in hundredths.
interface mcfb_req_if
    import mcfb_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [REQ_TYPE_W-1:0]      req_type;
    logic signed [VALUE_W-1:0]  value_hundredths;

    modport source (output valid, req_type, value_hundredths, input ready);
    modport sink   (input valid, req_type, value_hundredths, output ready);
endinterface

FILE: design/mcfb_byte_if.sv
// Frame byte channel interface: one frame byte per transaction.
interface mcfb_byte_if
    import mcfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
    logic              no_frame;

    modport source (output valid, frame_byte, last_byte, no_frame, input ready);
    modport sink   (input valid, frame_byte, last_byte, no_frame, output ready);
endinterface

FILE: design/mcfb_front.sv
// Front end: accepts commands, decodes them, clamps values and does the first divide by 100.
module mcfb_front
    import mcfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcfb_req_if.sink   req,
    input  cfg_t       cfg,
    output logic       push_valid,
    input  logic       push_ready,
    output desc_t      push_desc
);

    // x / 100 for x below 2**22 by reciprocal multiply.
    localparam int         DIV_SHIFT = 29;
    localparam logic [22:0] DIV_RECIP = 23'd5368710;

    localparam logic signed [22:0] SET_MAX   = 23'sd25599;
    localparam logic signed [22:0] PULSE_MAX = 23'sd25500;
    localparam logic signed [22:0] POWER_MAX = 23'sd2559900;
    localparam logic [21:0]        HALF_UNIT = 22'd50;

    typedef struct packed {
        kind_t           kind;
        logic [5:0][7:0] fbytes;
        mode_t           mode;
        logic [21:0]     x;
    } stage_t;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    stage_t s1_reg;
    stage_t s1_next;
    logic   in_accept;

    logic [4:0]               code;
    logic signed [22:0]       h;
    logic [3:0]               pos;
    logic [15:0]              start;
    logic [44:0]              prod;
    logic [14:0]              q1;

    function automatic logic [21:0] clamp_to(input logic signed [22:0] v,
                                             input logic signed [22:0] hi);
        logic [21:0] r;
        if (v < 0)
            r = '0;
        else if (v > hi)
            r = hi[21:0];
        else
            r = v[21:0];
        return r;
    endfunction

    function automatic logic [7:0] onoff_fn(input logic [2:0] pair);
        logic [7:0] f;
        case (pair)
            3'd0:    f = FN_FORCE;
            3'd1:    f = FN_CO;
            3'd2:    f = FN_SUMP;
            3'd3:    f = FN_COLD_PUMP;
            3'd4:    f = FN_HOT_PUMP;
            default: f = 8'h00;
        endcase
        return f;
    endfunction

    assign code      = req.req_type;
    assign h         = req.value_hundredths;
    assign pos       = 4'(code - REQ_ONOFF_FIRST);
    assign start     = (code == REQ_INV_BLOCK2) ? cfg.inv_first + {9'b0, cfg.block_cnt}
                                                : cfg.inv_first;
    assign req.ready = !s1_valid_reg || push_ready;
    assign in_accept = req.valid && req.ready;

    always_comb
    begin
        s1_next           = '0;
        s1_next.kind      = KIND_PUMP;
        s1_next.mode      = MODE_NONE;
        s1_next.fbytes[0] = PUMP_ADDR;
        s1_next.fbytes[4] = PUMP_END;
        case (code)
            REQ_PUMP_READ:
            begin
                s1_next.fbytes[1] = FN_PUMP_READ;
            end
            REQ_INV_BLOCK1, REQ_INV_BLOCK2:
            begin
                s1_next.kind      = KIND_INV;
                s1_next.fbytes[0] = cfg.inv_addr;
                s1_next.fbytes[1] = FN_INV_READ;
                s1_next.fbytes[2] = start[15:8];
                s1_next.fbytes[3] = start[7:0];
                s1_next.fbytes[4] = 8'h00;
                s1_next.fbytes[5] = {1'b0, cfg.block_cnt};
            end
            REQ_CO_SETPOINT, REQ_CO_DELTA, REQ_EEV_SETPOINT:
            begin
                s1_next.fbytes[1] = (code == REQ_CO_SETPOINT) ? FN_CO_SET :
                                    (code == REQ_CO_DELTA)    ? FN_CO_DELTA : FN_EEV_SET;
                s1_next.mode      = MODE_SPLIT;
                s1_next.x         = clamp_to(h, SET_MAX);
            end
            REQ_EEV_MAX_PULSES, REQ_EEV_MIN_POS:
            begin
                s1_next.fbytes[1] = (code == REQ_EEV_MAX_PULSES) ? FN_EEV_MAX : FN_EEV_MIN;
                s1_next.mode      = MODE_ROUND;
                s1_next.x         = clamp_to(h, PULSE_MAX) + HALF_UNIT;
            end
            REQ_WORK_POWER:
            begin
                s1_next.fbytes[1] = FN_POWER;
                s1_next.mode      = MODE_POWER;
                s1_next.x         = clamp_to(h, POWER_MAX) + HALF_UNIT;
            end
            default:
            begin
                if (code inside {[REQ_ONOFF_FIRST:REQ_ONOFF_LAST]})
                begin
                    s1_next.fbytes[1] = onoff_fn(pos[3:1]);
                    s1_next.fbytes[2] = {7'b0, !pos[0]};
                end
                else
                begin
                    s1_next.kind   = KIND_BAD;
                    s1_next.fbytes = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_reg <= s1_next;
    end

    // Second stage: first divide by 100, result goes straight into the queue register.
    assign prod = {23'b0, s1_reg.x} * {22'b0, DIV_RECIP};
    assign q1   = prod[DIV_SHIFT +: 15];

    always_comb
    begin
        push_desc           = '0;
        push_desc.kind      = s1_reg.kind;
        push_desc.fbytes    = s1_reg.fbytes;
        case (s1_reg.mode)
            MODE_SPLIT:
            begin
                push_desc.split     = 1'b1;
                push_desc.split_val = s1_reg.x[14:0];
            end
            MODE_ROUND:
            begin
                push_desc.fbytes[2] = q1[7:0];
            end
            MODE_POWER:
            begin
                push_desc.split     = 1'b1;
                push_desc.split_val = q1;
            end
            default:
            begin
                push_desc.split     = 1'b0;
            end
        endcase
    end

    assign push_valid = s1_valid_reg;

endmodule

FILE: design/mcfb_queue.sv
// Small register queue of frame descriptors between the front and back ends.
module mcfb_queue
    import mcfb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  desc_t push_desc,
    output logic  pop_valid,
    input  logic  pop_ready,
    output desc_t pop_desc
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

FILE: design/mcfb_back.sv
// Back end: loads a descriptor, splits values by 100, sends bytes and builds the CRC.
module mcfb_back
    import mcfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  desc_t       pop_desc,
    mcfb_byte_if.source rsp
);

    // w / 100 for w below 2**15 by reciprocal multiply.
    localparam int          SPLIT_SHIFT = 22;
    localparam logic [15:0] SPLIT_RECIP = 16'd41944;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [2:0]  INV_LAST    = 3'd7;
    localparam logic [2:0]  PUMP_LAST   = 3'd4;
    localparam logic [2:0]  BAD_LAST    = 3'd0;
    localparam logic [2:0]  CRC_LO_IDX  = 3'd6;

    logic            busy_reg, busy_next;
    logic [2:0]      idx_reg, idx_next;
    logic [2:0]      last_idx_reg, last_idx_next;
    logic            bad_reg, bad_next;
    logic [15:0]     crc_reg, crc_next;
    logic [5:0][7:0] fb_reg, fb_next;

    logic            load;
    logic            out_accept;
    logic            is_last;
    logic [30:0]     prod;
    logic [7:0]      q2;
    logic [14:0]     q2_x100;
    logic [14:0]     rem;
    logic [7:0]      cur_byte;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] t;
        t = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        return t;
    endfunction

    assign is_last    = idx_reg == last_idx_reg;
    assign out_accept = rsp.valid && rsp.ready;
    assign pop_ready  = !busy_reg || (rsp.ready && is_last);
    assign load       = pop_valid && pop_ready;

    assign prod    = {16'b0, pop_desc.split_val} * {15'b0, SPLIT_RECIP};
    assign q2      = prod[SPLIT_SHIFT +: 8];
    assign q2_x100 = {1'b0, q2, 6'b0} + {2'b0, q2, 5'b0} + {5'b0, q2, 2'b0};
    assign rem     = pop_desc.split_val - q2_x100;

    always_comb
    begin
        case (idx_reg)
            3'd0:       cur_byte = fb_reg[0];
            3'd1:       cur_byte = fb_reg[1];
            3'd2:       cur_byte = fb_reg[2];
            3'd3:       cur_byte = fb_reg[3];
            3'd4:       cur_byte = fb_reg[4];
            3'd5:       cur_byte = fb_reg[5];
            CRC_LO_IDX: cur_byte = crc_reg[7:0];
            default:    cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        bad_next      = bad_reg;
        crc_next      = crc_reg;
        fb_next       = fb_reg;
        if (out_accept)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg < CRC_LO_IDX)
                crc_next = crc_byte(crc_reg, cur_byte);
            if (is_last)
                busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            crc_next  = CRC_INIT;
            bad_next  = pop_desc.kind == KIND_BAD;
            fb_next   = pop_desc.fbytes;
            if (pop_desc.split)
            begin
                fb_next[2] = q2;
                fb_next[3] = {1'b0, rem[6:0]};
            end
            case (pop_desc.kind)
                KIND_INV:  last_idx_next = INV_LAST;
                KIND_PUMP: last_idx_next = PUMP_LAST;
                default:   last_idx_next = BAD_LAST;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= '0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        fb_reg  <= fb_next;
    end

    assign rsp.valid      = busy_reg;
    assign rsp.frame_byte = cur_byte;
    assign rsp.last_byte  = is_last;
    assign rsp.no_frame   = bad_reg;

endmodule

FILE: design/modbus_command_frame_builder_top.sv
// Top level of the Modbus command frame builder: configuration registers and the three stages.
//
//  Channel  Role    Transaction
//  -------  ------  ----------------------------------------------------------
//  req      sink    one command: req_type, value_hundredths
//  rsp      source  one frame byte: frame_byte, last_byte, no_frame
//  APB      slave   write or read of inverter_address, inverter_first_register,
//                   block_register_count at byte addresses 0, 4 and 8
//
// A command is decoded and clamped into the front end's single register, and
// the first divide by 100 is done as the descriptor is written into the queue,
// so with an empty queue and an idle back end a command passes the front end
// register, the queue and then the back end before its first byte is presented.
// The back end sends one byte per cycle while the output takes them; inverter
// frames have 8 bytes, pump frames 5 and an unknown code 1. The output port's
// one byte per cycle sets the sustained rate, and the next frame's first byte
// follows the last byte of the previous one without a gap. While the output
// stalls, the queue and the front end keep taking commands until they are
// full. Reset is asynchronous and active low; it empties all stages and
// restores the register reset values.
// The CRC-16 is built one byte per cycle as bytes 0 to 5 leave the block.
module modbus_command_frame_builder_top
    import mcfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2   // descriptors held between front and back end, at least 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    mcfb_req_if.sink    req,
    mcfb_byte_if.source rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  inv_addr_reg, inv_addr_next;
    logic [15:0] inv_first_reg, inv_first_next;
    logic [6:0]  block_cnt_reg, block_cnt_next;
    logic        cfg_write;
    cfg_t        cfg;

    logic        push_valid, push_ready;
    desc_t       push_desc;
    logic        pop_valid, pop_ready;
    desc_t       pop_desc;

    // Configuration port. Writes complete in the access cycle; pready is tied high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        inv_addr_next  = inv_addr_reg;
        inv_first_next = inv_first_reg;
        block_cnt_next = block_cnt_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_INV_ADDR:  inv_addr_next  = pwdata[7:0];
                REG_INV_FIRST: inv_first_next = pwdata[15:0];
                REG_BLOCK_CNT: block_cnt_next = pwdata[6:0];
                default:       inv_addr_next  = inv_addr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_INV_ADDR:  prdata = {24'b0, inv_addr_reg};
            REG_INV_FIRST: prdata = {16'b0, inv_first_reg};
            REG_BLOCK_CNT: prdata = {25'b0, block_cnt_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_addr_reg  <= 8'd1;
            inv_first_reg <= 16'd0;
            block_cnt_reg <= 7'd1;
        end
        else
        begin
            inv_addr_reg  <= inv_addr_next;
            inv_first_reg <= inv_first_next;
            block_cnt_reg <= block_cnt_next;
        end
    end

    assign cfg.inv_addr  = inv_addr_reg;
    assign cfg.inv_first = inv_first_reg;
    assign cfg.block_cnt = block_cnt_reg;

    mcfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    mcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    mcfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .rsp       (rsp)
    );

    // An unknown code gives a single zero byte that also closes the frame.
    a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.no_frame |-> rsp.last_byte && rsp.frame_byte == 8'h00)
        else $error("unknown-code result is not a single closing zero byte");

    // The front end must hold its descriptor while the queue is full.
    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && !push_ready |=> push_valid && $stable(push_desc))
        else $error("front end dropped or changed a descriptor while the queue was full");

    // A descriptor taken by the back end shows up as a frame byte in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> rsp.valid)
        else $error("back end loaded a descriptor but presents no byte");

endmodule
